// ----- rtl/prl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package prl_pkg;

   // Field widths of the request and response items.
   localparam int unsigned OPERATION_W     = 1;
   localparam int unsigned SET_INDEX_W     = 11;
   localparam int unsigned WAY_INDEX_W     = 4;
   localparam int unsigned PC_LOW_W        = 32;
   localparam int unsigned PHYS_ADDR_W     = 48;
   localparam int unsigned VALID_MASK_W    = 16;
   localparam int unsigned VICTIM_WAY_W    = 4;

   // Configuration registers.
   localparam int unsigned THRESHOLD_W     = 2;
   localparam int unsigned LOW_POS_W       = 4;
   localparam int unsigned CSR_ADDR_W      = 3;
   localparam int unsigned CSR_DATA_W      = 32;
   localparam int unsigned CSR_WORD_W      = CSR_ADDR_W - 2;

   localparam logic [CSR_WORD_W-1:0] CSR_IDX_THRESHOLD = 1'b0;
   localparam logic [CSR_WORD_W-1:0] CSR_IDX_LOW_POS   = 1'b1;

   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 2'd2;
   localparam logic [LOW_POS_W-1:0]   LOW_POS_RESET   = 4'd8;

   // Block address is the physical address without the line offset.
   localparam int unsigned BLOCK_SHIFT     = 6;
   localparam int unsigned COUNTER_RESET   = 2;

   typedef enum logic [OPERATION_W-1:0] {
      OP_QUERY  = 1'b0,
      OP_UPDATE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_SUB,
      ST_READ,
      ST_EXEC
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/prl_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface prl_req_if
   import prl_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [OPERATION_W-1:0]  operation;
   logic [SET_INDEX_W-1:0]  set_index;
   logic [WAY_INDEX_W-1:0]  way_index;
   logic [PC_LOW_W-1:0]     pc_low;
   logic [PHYS_ADDR_W-1:0]  phys_addr;
   logic                    was_hit;
   logic [VALID_MASK_W-1:0] valid_mask;

   modport source (
      output valid, operation, set_index, way_index, pc_low, phys_addr, was_hit,
             valid_mask,
      input  ready
   );

   modport sink (
      input  valid, operation, set_index, way_index, pc_low, phys_addr, was_hit,
             valid_mask,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/prl_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface prl_rsp_if
   import prl_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [VICTIM_WAY_W-1:0] victim_way;
   logic                    low_priority_fill;

   modport source (
      output valid, victim_way, low_priority_fill,
      input  ready
   );

   modport sink (
      input  valid, victim_way, low_priority_fill,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/pc_reuse_lru_two_position_insert.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake      Contents
// req       in   valid/ready    operation, set, way, pc, address, hit, valid mask
// rsp       out  valid/ready    victim way, low-priority fill flag
// APB       in   psel/penable   reuse threshold (word 0), low insert position (word 1)
//
// Each request passes from acceptance to the next acceptance through two
// multiply steps of the set and counter index reduction, one subtract step,
// one synchronous memory read and one read-modify-write of the set row.
// After reset a clearing pass over max(NUM_SETS, COUNTER_ENTRIES) entries
// initialises both memories; no request is accepted until it ends.
// A response waits in an output register; while it is stalled the block may
// accept and work on the next request up to its write-back.
module pc_reuse_lru_two_position_insert
   import prl_pkg::*;
#(
   parameter int unsigned NUM_SETS        = 2048,
   parameter int unsigned NUM_WAYS        = 16,
   parameter int unsigned COUNTER_ENTRIES = 2048,
   parameter int unsigned COUNTER_LIMIT   = 3
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   prl_req_if.sink                    req,
   prl_rsp_if.source                  rsp,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int unsigned POS_W     = $clog2(NUM_WAYS);
   localparam int unsigned ROW_W     = NUM_WAYS * POS_W;
   localparam int unsigned SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int unsigned CIDX_W    = $clog2(COUNTER_ENTRIES);
   localparam int unsigned CNT_MAX   = (COUNTER_LIMIT > COUNTER_RESET) ?
                                       COUNTER_LIMIT : COUNTER_RESET;
   localparam int unsigned CNT_W     = $clog2(CNT_MAX + 1);
   localparam int unsigned CLR_DEPTH = (NUM_SETS > COUNTER_ENTRIES) ?
                                       NUM_SETS : COUNTER_ENTRIES;
   localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);
   localparam int unsigned MASK_WAYS = (NUM_WAYS < VALID_MASK_W) ?
                                       NUM_WAYS : VALID_MASK_W;

   localparam logic [POS_W-1:0] LRU_POS   = POS_W'(NUM_WAYS - 1);
   localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(COUNTER_RESET);
   localparam logic [CLR_W-1:0] CLR_LAST  = CLR_W'(CLR_DEPTH - 1);

   // Memories: one row of stack positions per set, one counter per entry.
   logic [ROW_W-1:0] lru_mem [NUM_SETS];
   logic [CNT_W-1:0] cnt_mem [COUNTER_ENTRIES];

   state_type state_ff, state_in;

   logic [CLR_W-1:0]       clr_ff;
   logic [THRESHOLD_W-1:0] thr_ff;
   logic [LOW_POS_W-1:0]   low_ff;

   logic                    op_ff;
   logic [WAY_INDEX_W-1:0]  way_ff;
   logic                    hit_ff;
   logic [VALID_MASK_W-1:0] mask_ff;

   logic [SET_W-1:0]  set_ff;
   logic [CIDX_W-1:0] cidx_ff;
   logic [ROW_W-1:0]  row_rd_ff;
   logic [CNT_W-1:0]  cnt_rd_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VICTIM_WAY_W-1:0] victim_ff;
   logic                    lowfill_ff;

   logic              mem_clear;
   logic              rd_en;
   logic              exec_load;
   logic              accept;
   logic [SET_W-1:0]  set_rem;
   logic [CIDX_W-1:0] cidx_rem;
   logic [PC_LOW_W-1:0] hash_x;

   logic [ROW_W-1:0]        reset_row;
   logic [ROW_W-1:0]        row_new;
   logic [CNT_W-1:0]        cnt_new;
   logic [POS_W-1:0]        pos_from;
   logic [POS_W-1:0]        pos_target;
   logic [POS_W-1:0]        low_sat;
   logic [POS_W-1:0]        pos_w;
   logic [VICTIM_WAY_W-1:0] victim_new;
   logic                    lowfill_new;
   logic                    way_ok;
   logic                    is_update;
   logic                    mru_fill;
   logic                    found;
   logic                    wr_en;
   logic                    csr_wr;
   logic [CSR_WORD_W-1:0]   csr_word;

   // ---------------------------------------------------------------- index units
   assign hash_x = req.pc_low ^ req.phys_addr[BLOCK_SHIFT +: PC_LOW_W];

   prl_const_mod #(
      .IN_W    (SET_INDEX_W),
      .DIVISOR (NUM_SETS)
   ) u_set_mod (
      .clock (clock),
      .x     (req.set_index),
      .rem   (set_rem)
   );

   prl_const_mod #(
      .IN_W    (PC_LOW_W),
      .DIVISOR (COUNTER_ENTRIES)
   ) u_cidx_mod (
      .clock (clock),
      .x     (hash_x),
      .rem   (cidx_rem)
   );

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_clear) begin
            clr_ff <= clr_ff + CLR_W'(1);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      mem_clear = 1'b0;
      rd_en     = 1'b0;
      exec_load = 1'b0;
      req.ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_clear = 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_SUB;
         end
         ST_SUB: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            // The row is written back only once the response register is free.
            if (!rsp_valid_ff || rsp.ready) begin
               exec_load = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign accept = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req.operation;
         way_ff  <= req.way_index;
         hit_ff  <= req.was_hit;
         mask_ff <= req.valid_mask;
      end
   end

   // ---------------------------------------------------------------- memories
   always_comb begin
      reset_row = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         reset_row[w*POS_W +: POS_W] = POS_W'(w);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_clear) begin
         if (32'(clr_ff) < NUM_SETS) begin
            lru_mem[clr_ff[SET_W-1:0]] <= reset_row;
         end
         if (32'(clr_ff) < COUNTER_ENTRIES) begin
            cnt_mem[clr_ff[CIDX_W-1:0]] <= CNT_RESET;
         end
      end else if (wr_en) begin
         lru_mem[set_ff]  <= row_new;
         cnt_mem[cidx_ff] <= cnt_new;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         row_rd_ff <= lru_mem[set_rem];
         cnt_rd_ff <= cnt_mem[cidx_rem];
         set_ff    <= set_rem;
         cidx_ff   <= cidx_rem;
      end
   end

   // ---------------------------------------------------------------- row update
   always_comb begin
      is_update = (op_ff == OP_UPDATE);
      way_ok    = (32'(way_ff) < NUM_WAYS);

      if (32'(low_ff) > NUM_WAYS - 1) begin
         low_sat = LRU_POS;
      end else begin
         low_sat = POS_W'(low_ff);
      end

      if (hit_ff) begin
         cnt_new  = (32'(cnt_rd_ff) < COUNTER_LIMIT) ? cnt_rd_ff + CNT_W'(1) : cnt_rd_ff;
         mru_fill = 1'b1;
      end else begin
         cnt_new  = (cnt_rd_ff != '0) ? cnt_rd_ff - CNT_W'(1) : cnt_rd_ff;
         mru_fill = (32'(cnt_new) >= 32'(thr_ff));
      end
      pos_target = mru_fill ? '0 : low_sat;

      pos_from = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (32'(way_ff) == w) begin
            pos_from = row_rd_ff[w*POS_W +: POS_W];
         end
      end

      // The moved way takes the target place; ways in between shift one
      // step towards its old place, so the row remains a permutation.
      row_new = row_rd_ff;
      for (int w = 0; w < NUM_WAYS; w++) begin
         pos_w = row_rd_ff[w*POS_W +: POS_W];
         if (32'(way_ff) == w) begin
            row_new[w*POS_W +: POS_W] = pos_target;
         end else if (pos_target < pos_from && pos_w >= pos_target && pos_w < pos_from) begin
            row_new[w*POS_W +: POS_W] = pos_w + POS_W'(1);
         end else if (pos_target > pos_from && pos_w > pos_from && pos_w <= pos_target) begin
            row_new[w*POS_W +: POS_W] = pos_w - POS_W'(1);
         end
      end

      // Victim search: first invalid way, else the way in the LRU place.
      victim_new = '0;
      found      = 1'b0;
      for (int w = 0; w < MASK_WAYS; w++) begin
         if (!found && !mask_ff[w]) begin
            victim_new = VICTIM_WAY_W'(w);
            found      = 1'b1;
         end
      end
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (!found && row_rd_ff[w*POS_W +: POS_W] == LRU_POS) begin
            victim_new = VICTIM_WAY_W'(w);
            found      = 1'b1;
         end
      end
      if (is_update) begin
         victim_new = '0;
      end

      lowfill_new = is_update && way_ok && !hit_ff && !mru_fill;
      wr_en       = exec_load && is_update && way_ok;
   end

   // ---------------------------------------------------------------- response
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_load) begin
         victim_ff  <= victim_new;
         lowfill_ff <= lowfill_new;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.victim_way        = victim_ff;
   assign rsp.low_priority_fill = lowfill_ff;

   // ---------------------------------------------------------------- registers
   assign csr_word = paddr[CSR_ADDR_W-1:2];
   assign csr_wr   = psel && penable && pwrite && pready;
   assign pready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
         low_ff <= LOW_POS_RESET;
      end else if (csr_wr) begin
         unique case (csr_word)
            CSR_IDX_THRESHOLD: thr_ff <= pwdata[THRESHOLD_W-1:0];
            CSR_IDX_LOW_POS:   low_ff <= pwdata[LOW_POS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_word)
         CSR_IDX_THRESHOLD: prdata = CSR_DATA_W'(thr_ff);
         CSR_IDX_LOW_POS:   prdata = CSR_DATA_W'(low_ff);
         default:           prdata = '0;
      endcase
   end

`ifndef ASSERT_OFF
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MUL)
      else $error("accepted request did not start the index reduction");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("response raised outside the write-back step");

   a_exec_returns: assert property (@(posedge clock) disable iff (reset)
      exec_load |=> state_ff == ST_IDLE && rsp_valid_ff)
      else $error("write-back did not hand over a response");

   a_lowfill_update: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.low_priority_fill |-> rsp.victim_way == '0)
      else $error("low-priority fill flagged on a victim query");

   a_set_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |-> 32'(set_ff) < NUM_SETS && 32'(cidx_ff) < COUNTER_ENTRIES)
      else $error("reduced index out of range");
`endif

endmodule

`default_nettype wire

// ----- rtl/prl_const_mod.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Remainder by a constant in three registered steps: estimate the quotient
// with a reciprocal, subtract quotient times divisor, then correct once.
// The estimate is never more than one below the true quotient.
module prl_const_mod
   import prl_pkg::*;
#(
   parameter int unsigned IN_W    = 32,
   parameter int unsigned DIVISOR = 2048
) (
   input  wire logic                                        clock,
   input  wire logic [IN_W-1:0]                             x,
   output logic      [((DIVISOR > 1) ? $clog2(DIVISOR) : 1)-1:0] rem
);

   localparam int unsigned     OUT_W   = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
   localparam int unsigned     RECIP_W = IN_W + 1;
   localparam int unsigned     PROD_W  = IN_W + RECIP_W;
   localparam int unsigned     DIV_W   = $clog2(DIVISOR + 1);
   localparam int unsigned     QD_W    = IN_W + DIV_W;
   localparam longint unsigned RECIP   = (64'd1 << IN_W) / DIVISOR;

   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
   localparam logic [DIV_W-1:0]   DIV_C   = DIV_W'(DIVISOR);

   logic [IN_W-1:0]   x1_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [IN_W-1:0]   x2_ff;
   logic [IN_W-1:0]   qd_ff;
   logic [OUT_W-1:0]  rem_ff;

   logic [IN_W-1:0]   quot;
   logic [IN_W-1:0]   diff;
   logic [IN_W-1:0]   fixed;

   always_comb begin
      quot = prod_ff[IN_W +: IN_W];
      diff = x2_ff - qd_ff;
      if (64'(diff) >= 64'(DIVISOR)) begin
         fixed = diff - IN_W'(DIVISOR);
      end else begin
         fixed = diff;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff   <= x;
      prod_ff <= PROD_W'(x) * PROD_W'(RECIP_C);
      x2_ff   <= x1_ff;
      qd_ff   <= IN_W'(QD_W'(quot) * QD_W'(DIV_C));
      rem_ff  <= OUT_W'(fixed);
   end

   assign rem = rem_ff;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import prl_pkg::*;

   localparam int unsigned SETS       = 2048;
   localparam int unsigned WAYS       = 16;
   localparam int unsigned CTR_COUNT  = 2048;
   localparam int unsigned CTR_MAX    = 3;
   localparam int unsigned RUN_LIMIT  = 400000;
   localparam int unsigned PHASE_REQS = 200;

   typedef struct {
      op_type                  operation;
      logic [SET_INDEX_W-1:0]  set_index;
      logic [WAY_INDEX_W-1:0]  way_index;
      logic [PC_LOW_W-1:0]     pc_low;
      logic [PHYS_ADDR_W-1:0]  phys_addr;
      logic                    was_hit;
      logic [VALID_MASK_W-1:0] valid_mask;
   } cache_request_type;

   typedef struct {
      logic [VICTIM_WAY_W-1:0] victim;
      logic                    low_fill;
   } victim_result_type;

   typedef struct {
      bit                fixed;
      victim_result_type res;
   } known_result_type;

   typedef struct {
      cache_request_type rq;
      known_result_type  known;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;

   prl_req_if req_ch ();
   prl_rsp_if rsp_ch ();

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   pc_reuse_lru_two_position_insert u_top (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch.sink),
      .rsp     (rsp_ch.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Predicted replacement state, updated as each request is accepted.
   logic [3:0]             pos_model [SETS][WAYS];
   logic [1:0]             reuse_ctr [CTR_COUNT];
   logic [THRESHOLD_W-1:0] cfg_threshold = THRESHOLD_RESET;
   logic [LOW_POS_W-1:0]   cfg_low_pos   = LOW_POS_RESET;

   victim_result_type awaited_victims [$];
   known_result_type  typed_results [$];
   int unsigned       mismatches = 0;
   int unsigned       cycles = 0;

   logic [SET_INDEX_W-1:0] hot_sets   [8];
   logic [PC_LOW_W-1:0]    hot_pcs    [4];
   logic [10:0]            hot_blocks [4];

   initial begin
      for (int unsigned s = 0; s < SETS; s++) begin
         for (int unsigned w = 0; w < WAYS; w++) begin
            pos_model[s][w] = w[3:0];
         end
      end
      for (int unsigned i = 0; i < CTR_COUNT; i++) begin
         reuse_ctr[i] = 2'(COUNTER_RESET);
      end
   end

   // Moves a way to a new stack position; the ways in between slide one place
   // towards the vacated slot so that the set stays a permutation.
   function automatic void restack(int unsigned s, int unsigned way, int unsigned target);
      int unsigned from;
      int unsigned p;
      from = pos_model[s][way];
      for (int unsigned w = 0; w < WAYS; w++) begin
         p = pos_model[s][w];
         if (w != way) begin
            if (target < from && p >= target && p < from) begin
               pos_model[s][w] = 4'(p + 1);
            end else if (target > from && p > from && p <= target) begin
               pos_model[s][w] = 4'(p - 1);
            end
         end
      end
      pos_model[s][way] = 4'(target);
   endfunction

   function automatic victim_result_type apply_request(cache_request_type r);
      victim_result_type res;
      int unsigned       s;
      int unsigned       idx;
      int unsigned       low;
      bit                found;
      res.victim   = '0;
      res.low_fill = 1'b0;
      s = r.set_index % SETS;
      found = 1'b0;
      if (r.operation == OP_QUERY) begin
         for (int unsigned w = 0; w < WAYS; w++) begin
            if (!found && w < VALID_MASK_W && !r.valid_mask[w]) begin
               res.victim = 4'(w);
               found = 1'b1;
            end
         end
         for (int unsigned w = 0; w < WAYS; w++) begin
            if (!found && pos_model[s][w] == 4'(WAYS - 1)) begin
               res.victim = 4'(w);
               found = 1'b1;
            end
         end
      end else if (r.way_index < WAYS) begin
         idx = (r.pc_low ^ 32'(r.phys_addr >> BLOCK_SHIFT)) % CTR_COUNT;
         if (r.was_hit) begin
            if (reuse_ctr[idx] < CTR_MAX) begin
               reuse_ctr[idx] = reuse_ctr[idx] + 2'd1;
            end
            restack(s, r.way_index, 0);
         end else begin
            low = (cfg_low_pos > WAYS - 1) ? WAYS - 1 : cfg_low_pos;
            if (reuse_ctr[idx] > 0) begin
               reuse_ctr[idx] = reuse_ctr[idx] - 2'd1;
            end
            if (reuse_ctr[idx] >= cfg_threshold) begin
               restack(s, r.way_index, 0);
            end else begin
               restack(s, r.way_index, low);
               res.low_fill = 1'b1;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == RUN_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // The response is checked before the request of the same edge is recorded,
   // so a response that overtakes its own request is still caught.
   always @(posedge clock) begin
      victim_result_type want;
      known_result_type  typed;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_victims.size() == 0) begin
               $display("%0t: response without outstanding request: victim_way %0d fill %0b",
                        $time, rsp_ch.victim_way, rsp_ch.low_priority_fill);
               mismatches++;
            end else begin
               want = awaited_victims.pop_front();
               if (rsp_ch.victim_way !== want.victim) begin
                  $display("%0t: victim_way expected %0d actual %0d",
                           $time, want.victim, rsp_ch.victim_way);
                  mismatches++;
               end
               if (rsp_ch.low_priority_fill !== want.low_fill) begin
                  $display("%0t: low_priority_fill expected %0b actual %0b",
                           $time, want.low_fill, rsp_ch.low_priority_fill);
                  mismatches++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            want = apply_request('{operation:  op_type'(req_ch.operation),
                                   set_index:  req_ch.set_index,
                                   way_index:  req_ch.way_index,
                                   pc_low:     req_ch.pc_low,
                                   phys_addr:  req_ch.phys_addr,
                                   was_hit:    req_ch.was_hit,
                                   valid_mask: req_ch.valid_mask});
            if (typed_results.size() != 0) begin
               typed = typed_results.pop_front();
               if (typed.fixed) begin
                  want = typed.res;
               end
            end
            awaited_victims.push_back(want);
         end
      end
   end

   // Response side: random stalls, with occasional stretches of none.
   initial begin
      int unsigned stall;
      int unsigned calm_left;
      rsp_ch.ready = 1'b0;
      calm_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (calm_left == 0 && $urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(20, 60);
         end
         if (calm_left != 0) begin
            calm_left--;
            stall = 0;
         end else begin
            stall = $urandom_range(0, 10);
         end
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   int unsigned req_calm_left = 0;

   function automatic int unsigned next_gap();
      if (req_calm_left == 0 && $urandom_range(0, 39) == 0) begin
         req_calm_left = $urandom_range(20, 60);
      end
      if (req_calm_left != 0) begin
         req_calm_left--;
         return 0;
      end
      return $urandom_range(0, 10);
   endfunction

   // Valid stays high from one request to the next when the gap is zero.
   task automatic send_request(input cache_request_type rq, input known_result_type known);
      int unsigned gap;
      gap = next_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      typed_results.push_back(known);
      req_ch.valid      <= 1'b1;
      req_ch.operation  <= rq.operation;
      req_ch.set_index  <= rq.set_index;
      req_ch.way_index  <= rq.way_index;
      req_ch.pc_low     <= rq.pc_low;
      req_ch.phys_addr  <= rq.phys_addr;
      req_ch.was_hit    <= rq.was_hit;
      req_ch.valid_mask <= rq.valid_mask;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (awaited_victims.size() != 0);
   endtask

   // Consecutive writes run back to back; csr_idle closes the transfer.
   task automatic write_csr(input logic [CSR_WORD_W-1:0] word, input int unsigned value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {word, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (word == CSR_IDX_THRESHOLD) begin
         cfg_threshold = value[THRESHOLD_W-1:0];
      end else begin
         cfg_low_pos = value[LOW_POS_W-1:0];
      end
   endtask

   task automatic csr_idle();
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic stim_row_type row(op_type op, int unsigned set_idx, int unsigned way,
                                        logic [31:0] pc, logic [47:0] addr, bit hit,
                                        logic [15:0] mask, bit fixed, int unsigned victim,
                                        bit low_fill);
      stim_row_type r;
      r.rq.operation       = op;
      r.rq.set_index       = SET_INDEX_W'(set_idx);
      r.rq.way_index       = WAY_INDEX_W'(way);
      r.rq.pc_low          = pc;
      r.rq.phys_addr       = addr;
      r.rq.was_hit         = hit;
      r.rq.valid_mask      = mask;
      r.known.fixed        = fixed;
      r.known.res.victim   = VICTIM_WAY_W'(victim);
      r.known.res.low_fill = low_fill;
      return r;
   endfunction

   function automatic cache_request_type random_request();
      cache_request_type r;
      int unsigned       pick;
      pick = $urandom_range(0, 99);
      r.operation  = OP_UPDATE;
      r.set_index  = hot_sets[$urandom_range(0, 7)];
      r.way_index  = WAY_INDEX_W'($urandom_range(0, 15));
      r.pc_low     = hot_pcs[$urandom_range(0, 3)];
      r.phys_addr  = PHYS_ADDR_W'({$urandom, $urandom});
      r.phys_addr[16:6] = hot_blocks[$urandom_range(0, 3)];
      r.was_hit    = 1'b0;
      r.valid_mask = VALID_MASK_W'($urandom);
      if (pick < 10) begin
         // Noise: every field drawn over its full range.
         r.operation = op_type'($urandom_range(0, 1));
         r.set_index = SET_INDEX_W'($urandom);
         r.pc_low    = $urandom;
         r.phys_addr = PHYS_ADDR_W'({$urandom, $urandom});
         r.was_hit   = 1'(($urandom));
      end else if (pick < 40) begin
         r.operation = OP_QUERY;
         if ($urandom_range(0, 9) < 7) begin
            r.valid_mask = 16'hFFFF;
         end else if ($urandom_range(0, 1) == 0) begin
            r.valid_mask = ~(16'h0001 << $urandom_range(0, 15));
         end else begin
            r.valid_mask = VALID_MASK_W'($urandom) | VALID_MASK_W'($urandom);
         end
      end else if (pick < 70) begin
         r.was_hit = 1'b1;
      end
      return r;
   endfunction

   initial begin
      stim_row_type stim_rows [$];
      int unsigned  phase_thr [6];
      int unsigned  phase_low [6];
      req_ch.valid      = 1'b0;
      req_ch.operation  = OP_QUERY;
      req_ch.set_index  = '0;
      req_ch.way_index  = '0;
      req_ch.pc_low     = '0;
      req_ch.phys_addr  = '0;
      req_ch.was_hit    = 1'b0;
      req_ch.valid_mask = '0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;

      hot_sets[0] = '0;
      hot_sets[1] = '1;
      for (int i = 2; i < 8; i++) hot_sets[i] = SET_INDEX_W'($urandom);
      hot_pcs[0] = '0;
      hot_pcs[1] = '1;
      for (int i = 2; i < 4; i++) hot_pcs[i] = $urandom;
      for (int i = 0; i < 4; i++) hot_blocks[i] = 11'($urandom);

      // After reset: threshold 2, low position 8, counters at 2, way w at position w.
      stim_rows.push_back(row(OP_QUERY, 0, 0, 0, 0, 0, 16'hFFFF, 1, 15, 0));
      stim_rows.push_back(row(OP_QUERY, 2047, 15, '1, '1, 1, 16'h0000, 1, 0, 0));
      stim_rows.push_back(row(OP_QUERY, 1, 0, 0, 0, 0, 16'h7FFF, 1, 15, 0));
      stim_rows.push_back(row(OP_QUERY, 2, 0, 0, 0, 0, 16'hBFFF, 1, 14, 0));
      stim_rows.push_back(row(OP_QUERY, 3, 0, 0, 0, 0, 16'hFFFE, 1, 0, 0));
      stim_rows.push_back(row(OP_QUERY, 2047, 15, '1, '1, 1, 16'hFFFF, 1, 15, 0));
      // Repeated hits saturate the counter; a hit never fills low.
      stim_rows.push_back(row(OP_UPDATE, 5, 3, 0, 0, 1, 16'h0000, 1, 0, 0));
      stim_rows.push_back(row(OP_UPDATE, 5, 3, 0, 0, 1, 16'h0000, 1, 0, 0));
      stim_rows.push_back(row(OP_UPDATE, 5, 3, 0, 0, 1, 16'hFFFF, 1, 0, 0));
      stim_rows.push_back(row(OP_UPDATE, 5, 15, '1, '1, 0, 16'h0000, 0, 0, 0));
      stim_rows.push_back(row(OP_UPDATE, 5, 12, 0, 0, 0, 16'h0000, 0, 0, 0));
      // A fresh counter drops below the threshold on its first miss.
      stim_rows.push_back(row(OP_UPDATE, 6, 0, 32'h123, 0, 0, 16'h0000, 1, 0, 1));
      stim_rows.push_back(row(OP_UPDATE, 6, 0, 32'h123, 0, 0, 16'h0000, 0, 0, 0));
      stim_rows.push_back(row(OP_UPDATE, 6, 0, 32'h123, 0, 0, 16'h0000, 0, 0, 0));
      stim_rows.push_back(row(OP_UPDATE, 5, 15, 32'h123, 0, 0, 16'h0000, 0, 0, 0));
      stim_rows.push_back(row(OP_QUERY, 5, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0));
      stim_rows.push_back(row(OP_QUERY, 6, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0));
      stim_rows.push_back(row(OP_UPDATE, 6, 15, 32'h123, 0, 0, 16'h0000, 0, 0, 0));
      stim_rows.push_back(row(OP_QUERY, 6, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0));
      stim_rows.push_back(row(OP_UPDATE, 6, 7, 32'h1, 48'h40, 1, 16'h0000, 0, 0, 0));
      stim_rows.push_back(row(OP_UPDATE, 2047, 0, 0, 48'h7FC0, 0, 16'h0000, 0, 0, 0));
      stim_rows.push_back(row(OP_QUERY, 2047, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0));
      stim_rows.push_back(row(OP_QUERY, 6, 0, 0, 0, 0, 16'hFDFF, 0, 0, 0));

      phase_thr = '{0, 3, 1, 3, 0, 0};
      phase_low = '{15, 0, 4, 15, 0, 0};
      phase_thr[5] = $urandom_range(0, 3);
      phase_low[5] = $urandom_range(0, 15);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         send_request(stim_rows[i].rq, stim_rows[i].known);
      end

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         // Upper data bits are junk; only the register's own bits should stick.
         write_csr(CSR_IDX_THRESHOLD, ($urandom << THRESHOLD_W) | phase_thr[ph]);
         write_csr(CSR_IDX_LOW_POS, ($urandom << LOW_POS_W) | phase_low[ph]);
         csr_idle();
         for (int n = 0; n < PHASE_REQS; n++) begin
            // Now and then the sender holds off until every response is back.
            if (n % 97 == 50) begin
               drain();
            end
            send_request(random_request(), '{fixed: 1'b0, res: '{victim: '0, low_fill: 1'b0}});
         end
      end

      drain();
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
